FILE: hw/rtl/bfa_pkg.sv
// bfa_pkg: shared types, codes and helpers of the bitmap frame allocator.
// No dependencies.
package bfa_pkg;

  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned BIT_W       = 5;
  localparam int unsigned FRAME_SHIFT = 12;
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned FRAME_W     = ADDR_W - FRAME_SHIFT;
  localparam int unsigned CNT_W       = 19;
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned STATUS_W    = 3;

  localparam logic [CMD_W-1:0] CMD_ALLOC     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE      = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MARK_USED = 2'd2;
  localparam logic [CMD_W-1:0] CMD_MARK_FREE = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MISALIGNED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ALREADY    = 3'd4;

  typedef struct packed {
    logic                valid;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   frame_address;
    logic [CNT_W-1:0]    held_frames;
    logic [CNT_W-1:0]    free_frames;
  } rsp_t;

  // index of the lowest clear bit; word must hold at least one clear bit
  function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] word);
    logic [WORD_BITS-1:0] v;
    logic [BIT_W-1:0]     idx;
    v   = ~word;
    idx = '0;
    if (v[15:0] == '0) begin
      idx[4] = 1'b1;
      v      = v >> 16;
    end
    if (v[7:0] == '0) begin
      idx[3] = 1'b1;
      v      = v >> 8;
    end
    if (v[3:0] == '0) begin
      idx[2] = 1'b1;
      v      = v >> 4;
    end
    if (v[1:0] == '0) begin
      idx[1] = 1'b1;
      v      = v >> 2;
    end
    if (v[0] == 1'b0) begin
      idx[0] = 1'b1;
    end
    return idx;
  endfunction

endpackage

FILE: hw/rtl/bfa_bitmap_ram.sv
// bfa_bitmap_ram: single-port-write, single-port-read bitmap RAM,
// registered read data. No dependencies.
module bfa_bitmap_ram #(
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = 13
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: hw/rtl/bfa_ctrl.sv
// bfa_ctrl: command sequencer of the frame allocator: clear pass, first-fit
// scan, read-modify-write of bitmap words, free counter and result register.
// Depends on bfa_pkg.
module bfa_ctrl #(
  parameter int unsigned WORDS      = 8192,
  parameter int unsigned WIDX_W     = 13
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [bfa_pkg::CMD_W-1:0]        command_i,
  input  logic [bfa_pkg::ADDR_W-1:0]       address_i,
  input  logic [bfa_pkg::CNT_W-1:0]        frame_count_i,
  output logic                             mem_we_o,
  output logic [WIDX_W-1:0]                mem_waddr_o,
  output logic [bfa_pkg::WORD_BITS-1:0]    mem_wdata_o,
  output logic [WIDX_W-1:0]                mem_raddr_o,
  input  logic [bfa_pkg::WORD_BITS-1:0]    mem_rdata_i,
  output bfa_pkg::rsp_t                    rsp_o
);

  localparam int unsigned WCNT_W = $clog2(WORDS + 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MOD
  } state_e;

  state_e                          state_q, state_d;
  logic [WCNT_W-1:0]               clr_q, clr_d;
  logic [WCNT_W-1:0]               scan_q, scan_d;
  logic [WCNT_W-1:0]               hint_q, hint_d;
  logic [bfa_pkg::CMD_W-1:0]       cmd_q, cmd_d;
  logic [bfa_pkg::FRAME_W-1:0]     frame_q, frame_d;
  logic [bfa_pkg::CNT_W-1:0]       free_q, free_d;
  bfa_pkg::rsp_t                   rsp_q, rsp_d;

  logic [bfa_pkg::FRAME_W-1:0]     in_frame;
  logic [WCNT_W-1:0]               scan_nxt;
  logic [WCNT_W-1:0]               mod_word;
  logic [bfa_pkg::BIT_W-1:0]       zero_bit;
  logic [bfa_pkg::ADDR_W-1:0]      found;
  logic [bfa_pkg::BIT_W-1:0]       mod_bit;
  logic                            want_used;
  logic                            respond;
  logic [bfa_pkg::STATUS_W-1:0]    status;
  logic [bfa_pkg::ADDR_W-1:0]      faddr;

  assign busy     = (state_q != S_IDLE);
  assign in_frame = address_i[bfa_pkg::ADDR_W-1:bfa_pkg::FRAME_SHIFT];
  assign scan_nxt = scan_q + 1'b1;
  assign mod_word = WCNT_W'(frame_q[bfa_pkg::BIT_W +: WIDX_W]);
  assign zero_bit = bfa_pkg::lowest_zero(mem_rdata_i);
  assign found    = (bfa_pkg::ADDR_W'(scan_q) << bfa_pkg::BIT_W)
                  | bfa_pkg::ADDR_W'(zero_bit);
  assign mod_bit  = frame_q[bfa_pkg::BIT_W-1:0];
  assign want_used = (cmd_q == bfa_pkg::CMD_MARK_USED);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    scan_d      = scan_q;
    hint_d      = hint_q;
    cmd_d       = cmd_q;
    frame_d     = frame_q;
    free_d      = free_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = mem_rdata_i;
    mem_raddr_o = '0;
    respond     = 1'b0;
    status      = bfa_pkg::ST_DONE;
    faddr       = '0;

    case (state_q)
      S_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q[WIDX_W-1:0];
        mem_wdata_o = '1;
        clr_d       = clr_q + 1'b1;
        if (clr_q == WCNT_W'(WORDS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_d   = command_i;
          frame_d = in_frame;
          if (command_i == bfa_pkg::CMD_ALLOC) begin
            if ((32'(hint_q) << bfa_pkg::BIT_W) >= 32'(frame_count_i)) begin
              respond = 1'b1;
              status  = bfa_pkg::ST_NO_FREE;
            end else begin
              mem_raddr_o = hint_q[WIDX_W-1:0];
              scan_d      = hint_q;
              state_d     = S_SCAN;
            end
          end else if (command_i == bfa_pkg::CMD_FREE &&
                       address_i[bfa_pkg::FRAME_SHIFT-1:0] != '0) begin
            respond = 1'b1;
            status  = bfa_pkg::ST_MISALIGNED;
          end else if (32'(in_frame) >= 32'(frame_count_i)) begin
            respond = 1'b1;
            status  = bfa_pkg::ST_RANGE;
          end else begin
            mem_raddr_o = in_frame[bfa_pkg::BIT_W +: WIDX_W];
            state_d     = S_MOD;
          end
        end
      end
      S_SCAN: begin
        if (mem_rdata_i != '1) begin
          respond = 1'b1;
          if (found < 32'(frame_count_i)) begin
            mem_we_o    = 1'b1;
            mem_waddr_o = scan_q[WIDX_W-1:0];
            mem_wdata_o = mem_rdata_i | (bfa_pkg::WORD_BITS'(1) << zero_bit);
            free_d      = (free_q != '0) ? free_q - 1'b1 : free_q;
            hint_d      = scan_q;
            faddr       = found << bfa_pkg::FRAME_SHIFT;
          end else begin
            status = bfa_pkg::ST_NO_FREE;
          end
        end else begin
          // every word below scan_nxt is full
          hint_d = scan_nxt;
          if ((32'(scan_nxt) << bfa_pkg::BIT_W) >= 32'(frame_count_i)) begin
            respond = 1'b1;
            status  = bfa_pkg::ST_NO_FREE;
          end else begin
            mem_raddr_o = scan_nxt[WIDX_W-1:0];
            scan_d      = scan_nxt;
          end
        end
      end
      S_MOD: begin
        respond = 1'b1;
        if (mem_rdata_i[mod_bit] == want_used) begin
          status = bfa_pkg::ST_ALREADY;
        end else begin
          mem_we_o    = 1'b1;
          mem_waddr_o = mod_word[WIDX_W-1:0];
          if (want_used) begin
            mem_wdata_o = mem_rdata_i | (bfa_pkg::WORD_BITS'(1) << mod_bit);
            free_d      = (free_q != '0) ? free_q - 1'b1 : free_q;
          end else begin
            mem_wdata_o = mem_rdata_i & ~(bfa_pkg::WORD_BITS'(1) << mod_bit);
            free_d      = free_q + 1'b1;
            if (mod_word < hint_q) begin
              hint_d = mod_word;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (respond) begin
      state_d = S_IDLE;
    end

    rsp_d.valid         = respond;
    rsp_d.status        = status;
    rsp_d.frame_address = faddr;
    rsp_d.free_frames   = free_d;
    rsp_d.held_frames   = (frame_count_i > free_d) ? frame_count_i - free_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      scan_q  <= '0;
      hint_q  <= WCNT_W'(WORDS);
      cmd_q   <= bfa_pkg::CMD_ALLOC;
      frame_q <= '0;
      free_q  <= '0;
      rsp_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      scan_q  <= scan_d;
      hint_q  <= hint_d;
      cmd_q   <= cmd_d;
      frame_q <= frame_d;
      free_q  <= free_d;
      rsp_q   <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

`ifndef NO_ASSERTIONS
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_q.valid |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || rsp_q.valid))
    else $error("accepted command dropped");

  a_reject_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_q.valid && rsp_q.status != bfa_pkg::ST_DONE) |-> $stable(free_q))
    else $error("free count changed on a rejected command");

  a_reject_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_q.valid && rsp_q.status != bfa_pkg::ST_DONE) |-> rsp_q.frame_address == '0)
    else $error("frame address on a rejected command");

  a_write_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we_o && state_q != S_CLEAR) |=> (rsp_q.valid && rsp_q.status == bfa_pkg::ST_DONE))
    else $error("bitmap written without a completed command");
`endif

endmodule

FILE: hw/rtl/bitmap_frame_allocator_top.sv
// bitmap_frame_allocator_top: first-fit bitmap allocator of 4 KiB frames.
// Depends on bfa_pkg, bfa_bitmap_ram and bfa_ctrl.
//
// Channels: a command transaction is taken when start is high and busy is
// low (command_i, address_i). Each command gives exactly one result, shown on
// status_o, frame_address_o, held_frames_o and free_frames_o for the single
// cycle in which done_o is high; the receiver cannot stall it. frame_count
// is written on the cfg channel (cfg_valid_i and cfg_ready_o, always ready);
// the user must write it only while idle, as the block does not enforce it.
// Reset: the bitmap RAM is swept to all-used, one word per cycle, across its
// ceil(MAX_FRAMES/32) words (8192 by default); busy stays high meanwhile.
// Timing: done_o rises in the cycle after a command rejected on acceptance
// is taken; a free or mark passes through S_MOD and the result register.
// Allocate reads bitmap words in S_SCAN, one per cycle from a RAM with
// registered read, starting at the lowest word that may hold a free frame.
// busy is low while done_o is high, so the next command can be taken in the
// cycle of the result.
module bitmap_frame_allocator_top #(
  parameter int unsigned MAX_FRAMES = 262144
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [bfa_pkg::CMD_W-1:0]     command_i,
  input  logic [bfa_pkg::ADDR_W-1:0]    address_i,
  output logic                          done_o,
  output logic [bfa_pkg::STATUS_W-1:0]  status_o,
  output logic [bfa_pkg::ADDR_W-1:0]    frame_address_o,
  output logic [bfa_pkg::CNT_W-1:0]     held_frames_o,
  output logic [bfa_pkg::CNT_W-1:0]     free_frames_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bfa_pkg::CNT_W-1:0]     cfg_data_i
);

  localparam int unsigned WORDS  = (MAX_FRAMES + bfa_pkg::WORD_BITS - 1) / bfa_pkg::WORD_BITS;
  localparam int unsigned WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;

  logic [bfa_pkg::CNT_W-1:0]     frame_count_q, frame_count_d;
  logic                          mem_we;
  logic [WIDX_W-1:0]             mem_waddr;
  logic [bfa_pkg::WORD_BITS-1:0] mem_wdata;
  logic [WIDX_W-1:0]             mem_raddr;
  logic [bfa_pkg::WORD_BITS-1:0] mem_rdata;
  bfa_pkg::rsp_t                 rsp;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    frame_count_d = frame_count_q;
    if (cfg_valid_i && cfg_ready_o) begin
      if (32'(cfg_data_i) > 32'(MAX_FRAMES)) begin
        frame_count_d = bfa_pkg::CNT_W'(MAX_FRAMES);
      end else begin
        frame_count_d = cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= '0;
    end else begin
      frame_count_q <= frame_count_d;
    end
  end

  bfa_bitmap_ram #(
    .DEPTH (WORDS),
    .WIDTH (bfa_pkg::WORD_BITS),
    .AW    (WIDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  bfa_ctrl #(
    .WORDS      (WORDS),
    .WIDX_W     (WIDX_W)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .command_i     (command_i),
    .address_i     (address_i),
    .frame_count_i (frame_count_q),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata),
    .rsp_o         (rsp)
  );

  assign done_o          = rsp.valid;
  assign status_o        = rsp.status;
  assign frame_address_o = rsp.frame_address;
  assign held_frames_o   = rsp.held_frames;
  assign free_frames_o   = rsp.free_frames;

endmodule
